@@ rtl/core/sha_pkg.sv @@
// Shared types and constants of the SHA-256 stream hasher.
package sha_pkg;

	localparam int BLK_WORDS   = 16;
	localparam int CHAIN_WORDS = 8;
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	// Round constants
	localparam logic [31:0] K_TABLE [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Initial hash values
	localparam logic [31:0] H_INIT [CHAIN_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// Requests to the chaining-word store
	typedef struct packed {
		logic       rd_en;
		logic [2:0] rd_addr;
		logic       wr_en;   // write back read data plus addend
		logic [2:0] wr_addr;
		logic       clr_en;  // drop the entry back to its initial value
		logic [2:0] clr_addr;
	} chain_req_t;

	// Control of the round datapath
	typedef struct packed {
		logic       shift;      // shift working words, chaining word in at the top
		logic       round;      // perform one compression round
		logic       from_block; // take the schedule word from the block store
		logic [5:0] rnd;        // round number
	} rnd_ctrl_t;

endpackage

@@ rtl/core/sha_in_if.sv @@
// Message byte channel.
interface sha_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, output data_byte, output byte_present,
		output end_of_message, input ready);
	modport sink (input valid, input data_byte, input byte_present,
		input end_of_message, output ready);
endinterface

@@ rtl/core/sha_out_if.sv @@
// Digest word channel.
interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index,
		output last_word, input ready);
	modport sink (input valid, input digest_word, input word_index,
		input last_word, output ready);
endinterface

@@ rtl/core/sha_ram.sv @@
// Generic simple dual-port RAM with registered read.
module sha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; hold data when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/sha_chain.sv @@
// Chaining-word store: RAM with per-entry valid bits and read-modify-write add.
module sha_chain import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  chain_req_t  req,
	input  logic [31:0] addend,
	output logic [31:0] rdata
);

	logic [CHAIN_WORDS-1:0] valid_q;
	logic                   rd_ok_q;
	logic [2:0]             rd_addr_q;
	logic [31:0]            ram_rdata;
	logic [31:0]            wdata;

	// Add working word to the value read in the previous cycle
	assign wdata = rdata + addend;

	sha_ram #(
		.WIDTH (32),
		.DEPTH (CHAIN_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (req.wr_en),
		.waddr (req.wr_addr),
		.wdata (wdata),
		.re    (req.rd_en),
		.raddr (req.rd_addr),
		.rdata (ram_rdata)
	);

	// Track written entries; an unwritten entry reads as its initial value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_ok_q   <= 1'b0;
			rd_addr_q <= '0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.clr_en) begin
				valid_q[req.clr_addr] <= 1'b0;
			end
			if (req.rd_en) begin
				rd_ok_q   <= valid_q[req.rd_addr];
				rd_addr_q <= req.rd_addr;
			end
		end
	end

	assign rdata = rd_ok_q ? ram_rdata : H_INIT[rd_addr_q];

endmodule

@@ rtl/core/sha_round.sv @@
// Compression round datapath: working words, schedule window and round step.
module sha_round import sha_pkg::*; (
	input  logic        clk,
	input  rnd_ctrl_t   ctrl,
	input  logic [31:0] chain_word,
	input  logic [31:0] blk_word,
	output logic [31:0] head
);

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
	endfunction

	logic [31:0] v_q   [8];
	logic [31:0] sch_q [BLK_WORDS];
	logic [31:0] w;
	logic [31:0] ch;
	logic [31:0] mj;
	logic [31:0] t1;
	logic [31:0] t2;

	// Schedule word and round terms
	always_comb begin
		if (ctrl.from_block) begin
			w = blk_word;
		end else begin
			w = sch_q[0] + ssig0(sch_q[1]) + sch_q[9] + ssig1(sch_q[14]);
		end
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1 = v_q[7] + bsig1(v_q[4]) + ch + K_TABLE[ctrl.rnd] + w;
		t2 = bsig0(v_q[0]) + mj;
	end

	// Advance working words
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			for (int k = 0; k < 7; k++) begin
				v_q[k] <= v_q[k+1];
			end
			v_q[7] <= chain_word;
		end else if (ctrl.round) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
	end

	// Slide the schedule window once per round
	always_ff @(posedge clk) begin
		if (ctrl.round) begin
			for (int k = 0; k < BLK_WORDS - 1; k++) begin
				sch_q[k] <= sch_q[k+1];
			end
			sch_q[BLK_WORDS-1] <= w;
		end
	end

	assign head = v_q[0];

endmodule

@@ rtl/core/sha256_stream_hasher.sv @@
// Byte intake: one byte per cycle while idle; each full block is then compressed: chaining-word
// load, 64 rounds, then write-back through the store port.
// End of message: padding at one byte per cycle up to the block end, one or two compressions,
// then eight digest words, read one at a time from the chaining store's read port and held until taken.
// Reset clears all control; the chaining store reads as the initial hash values through
// per-entry valid bits, so no clearing pass is needed.
module sha256_stream_hasher import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sha_in_if.sink      msg,
	sha_out_if.source   digest
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PAD   = 3'd1;
	localparam logic [2:0] S_LOAD  = 3'd2;
	localparam logic [2:0] S_ROUND = 3'd3;
	localparam logic [2:0] S_ADD   = 3'd4;
	localparam logic [2:0] S_ORD   = 3'd5;
	localparam logic [2:0] S_OCAP  = 3'd6;

	logic [2:0]  state_q;
	logic [5:0]  cnt_q;
	logic [5:0]  fill_q;
	logic [23:0] wbuf_q;
	logic [63:0] bits_q;
	logic        pad_q;
	logic        mark_q;
	logic        len_q;
	logic        final_q;
	logic [2:0]  oidx_q;
	logic        out_valid_q;
	logic [31:0] out_word_q;
	logic [2:0]  out_idx_q;
	logic        out_last_q;

	logic        in_take;
	logic        len_byte;
	logic [7:0]  pad_byte;
	logic        push_en;
	logic [7:0]  push_val;
	logic        blk_we;
	logic        blk_re;
	logic [3:0]  blk_raddr;
	logic [31:0] blk_rdata;
	logic        cap;
	chain_req_t  chain_req;
	rnd_ctrl_t   rnd_ctrl;
	logic [31:0] chain_rdata;
	logic [31:0] head;

	assign msg.ready = (state_q == S_IDLE);
	assign in_take   = msg.valid && msg.ready;

	// Padding byte: mark, zeros, then the big-endian bit length
	always_comb begin
		len_byte = !mark_q && (len_q || fill_q == LEN_POS);
		if (mark_q) begin
			pad_byte = PAD_MARK;
		end else if (len_byte) begin
			pad_byte = bits_q[{~fill_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	// Byte path into the block store
	assign push_en  = (state_q == S_PAD) || (in_take && msg.byte_present);
	assign push_val = (state_q == S_PAD) ? pad_byte : msg.data_byte;
	assign blk_we   = push_en && (fill_q[1:0] == 2'b11);

	// Block words are fetched in the cycle before their round
	assign blk_re    = ((state_q == S_LOAD) && (cnt_q == 6'd8)) ||
		((state_q == S_ROUND) && (cnt_q < 6'd15));
	assign blk_raddr = (state_q == S_LOAD) ? 4'd0 : cnt_q[3:0] + 4'd1;

	sha_ram #(
		.WIDTH (32),
		.DEPTH (BLK_WORDS)
	) u_blk_ram (
		.clk   (clk),
		.we    (blk_we),
		.waddr (fill_q[5:2]),
		.wdata ({wbuf_q, push_val}),
		.re    (blk_re),
		.raddr (blk_raddr),
		.rdata (blk_rdata)
	);

	assign cap = (state_q == S_OCAP) && (!out_valid_q || digest.ready);

	// Chaining store accesses and round control
	always_comb begin
		chain_req          = '0;
		rnd_ctrl           = '0;
		rnd_ctrl.rnd       = cnt_q;
		rnd_ctrl.from_block = (cnt_q < 6'd16);
		case (state_q)
			S_LOAD: begin
				chain_req.rd_en   = (cnt_q < 6'd8);
				chain_req.rd_addr = cnt_q[2:0];
				rnd_ctrl.shift    = (cnt_q != 6'd0);
			end
			S_ROUND: begin
				rnd_ctrl.round = 1'b1;
			end
			S_ADD: begin
				chain_req.rd_en   = (cnt_q < 6'd8);
				chain_req.rd_addr = cnt_q[2:0];
				chain_req.wr_en   = (cnt_q != 6'd0);
				chain_req.wr_addr = cnt_q[2:0] - 3'd1;
				rnd_ctrl.shift    = (cnt_q != 6'd0);
			end
			S_ORD: begin
				chain_req.rd_en   = 1'b1;
				chain_req.rd_addr = oidx_q;
			end
			S_OCAP: begin
				chain_req.clr_en   = cap;
				chain_req.clr_addr = oidx_q;
			end
			default: begin
				chain_req = '0;
			end
		endcase
	end

	sha_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (chain_req),
		.addend (head),
		.rdata  (chain_rdata)
	);

	sha_round u_round (
		.clk        (clk),
		.ctrl       (rnd_ctrl),
		.chain_word (chain_rdata),
		.blk_word   (blk_rdata),
		.head       (head)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			fill_q      <= '0;
			bits_q      <= '0;
			pad_q       <= 1'b0;
			mark_q      <= 1'b0;
			len_q       <= 1'b0;
			final_q     <= 1'b0;
			oidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (push_en) begin
				fill_q <= fill_q + 6'd1;
			end

			// Hold a digest word until its transfer
			if (cap) begin
				out_valid_q <= 1'b1;
			end else if (digest.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if (msg.byte_present) begin
							bits_q <= bits_q + 64'd8;
						end
						if (msg.byte_present && fill_q == 6'd63) begin
							state_q <= S_LOAD;
							cnt_q   <= '0;
							pad_q   <= msg.end_of_message;
							mark_q  <= msg.end_of_message;
						end else if (msg.end_of_message) begin
							state_q <= S_PAD;
							pad_q   <= 1'b1;
							mark_q  <= 1'b1;
						end
					end
				end
				S_PAD: begin
					if (mark_q) begin
						mark_q <= 1'b0;
					end else if (fill_q == LEN_POS) begin
						len_q <= 1'b1;
					end
					if (fill_q == 6'd63) begin
						state_q <= S_LOAD;
						cnt_q   <= '0;
						if (len_byte) begin
							final_q <= 1'b1;
						end
					end
				end
				S_LOAD: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd8) begin
						state_q <= S_ROUND;
						cnt_q   <= '0;
					end
				end
				S_ROUND: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd8) begin
						cnt_q <= '0;
						if (final_q) begin
							state_q <= S_ORD;
							oidx_q  <= '0;
						end else if (pad_q) begin
							state_q <= S_PAD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_ORD: begin
					state_q <= S_OCAP;
				end
				S_OCAP: begin
					if (cap) begin
						if (oidx_q == 3'd7) begin
							state_q <= S_IDLE;
							pad_q   <= 1'b0;
							final_q <= 1'b0;
							len_q   <= 1'b0;
							bits_q  <= '0;
						end else begin
							oidx_q  <= oidx_q + 3'd1;
							state_q <= S_ORD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Byte assembly and output payload
	always_ff @(posedge clk) begin
		if (push_en) begin
			wbuf_q <= {wbuf_q[15:0], push_val};
		end
		if (cap) begin
			out_word_q <= chain_rdata;
			out_idx_q  <= oidx_q;
			out_last_q <= (oidx_q == 3'd7);
		end
	end

	assign digest.valid       = out_valid_q;
	assign digest.digest_word = out_word_q;
	assign digest.word_index  = out_idx_q;
	assign digest.last_word   = out_last_q;

`ifndef SYNTHESIS
	// Compression only ever starts on a block boundary
	a_blk_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD || state_q == S_ROUND) |-> (fill_q == 6'd0))
		else $error("compression running with a partly filled block");

	// Length bytes occupy the last eight places of the block
	a_len_place: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PAD && len_q) |-> (fill_q[5:3] == 3'b111))
		else $error("length byte outside the block tail");

	// The last flag marks the eighth digest word only
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		digest.valid |-> (digest.last_word == (digest.word_index == 3'd7)))
		else $error("last flag does not match word index");
`endif

endmodule
